// ----- src/afk_pkg.sv -----
// shared types, constants and rounding helpers for the arm pose block
`timescale 1ns / 1ps
`default_nettype none
package afk_pkg;

  localparam int AW = 16;                 // joint angle width
  localparam int LW = 16;                 // link length register width
  localparam int RW = 28;                 // internal q24 word
  localparam int PW = 2 * RW;             // product of two q24 words
  localparam int SW = PW + 2;             // sum of up to three products
  localparam int OW = 18;                 // output field width
  localparam int NJ = 6;                  // joints
  localparam int CORDIC_STEPS = 24;
  localparam int LINK_STAGES = 3;
  // accept edge to the edge that samples done
  localparam int PIPE_LAT = CORDIC_STEPS + LINK_STAGES * NJ + 2;

  typedef logic signed [RW-1:0] q_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] acc_t;
  typedef logic signed [OW-1:0] out_t;

  localparam q_t Q24_ONE     = 16777216;
  localparam q_t PI_Q        = 52707179;
  localparam q_t HALF_PI_Q   = 26353589;
  localparam q_t CORDIC_GAIN = 10188014;
  localparam acc_t RND_HALF  = 8388608;
  localparam logic signed [RW-9:0] OUT_MAX = 131071;
  localparam logic signed [RW-9:0] OUT_MIN = -131072;

  localparam q_t ATAN [CORDIC_STEPS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  // joint angle offset of each link
  typedef enum logic [1:0] {OFF_ZERO, OFF_POS, OFF_NEG} off_t;

  localparam off_t LINK_OFF [NJ] = '{OFF_NEG, OFF_POS, OFF_POS, OFF_ZERO, OFF_ZERO, OFF_POS};
  localparam logic signed [1:0] LINK_SF [NJ] = '{2'sd1, -2'sd1, 2'sd1, 2'sd1, 2'sd1, 2'sd0};
  localparam logic LINK_CF [NJ] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

  // configuration register indexes
  localparam logic [1:0] REG_UPPER   = 2'd0;
  localparam logic [1:0] REG_FOREARM = 2'd1;
  localparam logic [1:0] REG_WRIST   = 2'd2;

  typedef struct packed {
    q_t   c;
    q_t   s;
    logic neg;
  } trig_t;

  typedef struct packed {
    logic       vld;
    q_t [8:0]   rot;   // row * 3 + column
    q_t [2:0]   pos;
  } pose_t;

  // q24 product sum back to q24, round half up
  function automatic q_t rnd(input acc_t v);
    acc_t t;
    t = v + RND_HALF;
    return RW'(t >>> 24);
  endfunction

  // q24 to q16 output with saturation
  function automatic out_t sat_out(input q_t v);
    q_t t;
    logic signed [RW-9:0] r;
    t = v + q_t'(128);
    r = (RW-8)'(t >>> 8);
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return OW'(r);
  endfunction

endpackage
`default_nettype wire

// ----- src/afk_cordic.sv -----
// pipelined rotation-mode cordic lane giving cosine and sine of one joint
`timescale 1ns / 1ps
`default_nettype none
module afk_cordic import afk_pkg::*; (
  input  wire logic                 clk,
  input  wire logic signed [AW-1:0] angle,
  output trig_t                     trig
);

  q_t   x [CORDIC_STEPS+1];
  q_t   y [CORDIC_STEPS+1];
  q_t   z [CORDIC_STEPS+1];
  logic neg [CORDIC_STEPS+1];
  q_t   za;

  // fold into [-pi/2, pi/2]
  assign za = RW'(angle) <<< 11;

  always_ff @(posedge clk) begin
    x[0] <= CORDIC_GAIN;
    y[0] <= '0;
    if (za > HALF_PI_Q) begin
      z[0]   <= za - PI_Q;
      neg[0] <= 1'b1;
    end else if (za < -HALF_PI_Q) begin
      z[0]   <= za + PI_Q;
      neg[0] <= 1'b1;
    end else begin
      z[0]   <= za;
      neg[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      neg[i+1] <= neg[i];
      if (z[i] >= 0) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - ATAN[i];
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + ATAN[i];
      end
    end
  end

  assign trig.c   = x[CORDIC_STEPS];
  assign trig.s   = y[CORDIC_STEPS];
  assign trig.neg = neg[CORDIC_STEPS];

endmodule
`default_nettype wire

// ----- src/afk_link.sv -----
// one link of the pose chain: three stages applying a dh transform
`timescale 1ns / 1ps
`default_nettype none
module afk_link import afk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  off_t                   off,
  input  wire logic signed [1:0] sf,
  input  wire logic              cf,
  input  trig_t                  trig,
  input  q_t                     r_len,
  input  q_t                     d_len,
  input  pose_t                  pose_in,
  output pose_t                  pose_out
);

  q_t cq, sq, ct, st;
  q_t rin [9];

  // stage 1
  logic  v1;
  q_t    ct1, st1;
  prod_t pp0, pp1;
  q_t    rot1 [9];
  q_t    pos1 [3];

  // stage 2
  logic  v2;
  q_t    pt0, pt1;
  prod_t pa [3], pb [3], pc [3], pe [3], pf [3], pg [3], ph [3];
  q_t    r2c [3];
  q_t    pos2 [3];

  always_comb begin
    cq = trig.neg ? -trig.c : trig.c;
    sq = trig.neg ? -trig.s : trig.s;
    unique case (off)
      OFF_POS: begin ct = -sq; st = cq;  end
      OFF_NEG: begin ct = sq;  st = -cq; end
      default: begin ct = cq;  st = sq;  end
    endcase
    for (int i = 0; i < 9; i++) rin[i] = pose_in.rot[i];
  end

  always_ff @(posedge clk) begin
    ct1 <= ct;
    st1 <= st;
    pp0 <= r_len * ct;
    pp1 <= r_len * st;
    for (int i = 0; i < 9; i++) rot1[i] <= rin[i];
    for (int i = 0; i < 3; i++) pos1[i] <= pose_in.pos[i];
  end

  assign pt0 = rnd(acc_t'(pp0));
  assign pt1 = rnd(acc_t'(pp1));

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pa[i]   <= rot1[i*3]   * ct1;
      pb[i]   <= rot1[i*3+1] * st1;
      pc[i]   <= rot1[i*3]   * st1;
      pe[i]   <= rot1[i*3+1] * ct1;
      pf[i]   <= rot1[i*3]   * pt0;
      pg[i]   <= rot1[i*3+1] * pt1;
      ph[i]   <= rot1[i*3+2] * d_len;
      r2c[i]  <= rot1[i*3+2];
      pos2[i] <= pos1[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pose_out.rot[i*3] <= rnd(acc_t'(pa[i]) + acc_t'(pb[i]));
      if (cf) begin
        pose_out.rot[i*3+1] <= rnd(acc_t'(pe[i]) - acc_t'(pc[i]));
        pose_out.rot[i*3+2] <= r2c[i];
      end else if (sf == 2'sd1) begin
        pose_out.rot[i*3+1] <= r2c[i];
        pose_out.rot[i*3+2] <= rnd(acc_t'(pc[i]) - acc_t'(pe[i]));
      end else begin
        pose_out.rot[i*3+1] <= -r2c[i];
        pose_out.rot[i*3+2] <= rnd(acc_t'(pe[i]) - acc_t'(pc[i]));
      end
      pose_out.pos[i] <= rnd(acc_t'(pf[i]) + acc_t'(pg[i]) + acc_t'(ph[i])) + pos2[i];
    end
    if (rst) pose_out.vld <= 1'b0;
    else     pose_out.vld <= v2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= pose_in.vld;
      v2 <= v1;
    end
  end

endmodule
`default_nettype wire

// ----- src/arm_forward_kinematics.sv -----
// top level: six-joint arm forward kinematics
`timescale 1ns / 1ps
`default_nettype none
// Pose of a six-joint arm from its joint angles. A beat is taken at every
// clock edge with start high and busy low; busy is high only while rst is
// held, so one beat can enter every cycle. Each beat yields exactly one
// result, shown for one cycle with done high. The receiver cannot stall the
// block, so results must be captured the cycle done is high. The pipeline is
// the six cordic lanes (an input fold register and 24 stages, one per
// iteration, all joints in parallel) followed by a chain of six link units of
// three stages each and one output register. Link lengths are written through
// cfg_we/cfg_addr/cfg_data and are read live by the link units, so write them
// only while no beat is in flight. Angles are radians times 8192; outputs are
// q16 and saturate at +-2.
module arm_forward_kinematics import afk_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      done,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_addr,
  input  wire logic [LW-1:0]        cfg_data,
  input  wire logic signed [AW-1:0] joint1_angle,
  input  wire logic signed [AW-1:0] joint2_angle,
  input  wire logic signed [AW-1:0] joint3_angle,
  input  wire logic signed [AW-1:0] joint4_angle,
  input  wire logic signed [AW-1:0] joint5_angle,
  input  wire logic signed [AW-1:0] joint6_angle,
  output out_t                      col0_x,
  output out_t                      col0_y,
  output out_t                      col0_z,
  output out_t                      col1_x,
  output out_t                      col1_y,
  output out_t                      col1_z,
  output out_t                      col2_x,
  output out_t                      col2_y,
  output out_t                      col2_z,
  output out_t                      pos_x,
  output out_t                      pos_y,
  output out_t                      pos_z
);

  logic [LW-1:0] upper_arm_length;
  logic [LW-1:0] forearm_length;
  logic [LW-1:0] wrist_offset;

  logic                 accept;
  logic signed [AW-1:0] angle [NJ];
  trig_t                lane_t [NJ];
  trig_t                lane_d [NJ];
  logic [CORDIC_STEPS:0] trig_vld;
  q_t                   r_len [NJ];
  q_t                   d_len [NJ];
  pose_t                chain [NJ+1];

  assign busy   = rst;
  assign accept = start && !busy;

  assign angle[0] = joint1_angle;
  assign angle[1] = joint2_angle;
  assign angle[2] = joint3_angle;
  assign angle[3] = joint4_angle;
  assign angle[4] = joint5_angle;
  assign angle[5] = joint6_angle;

  // link length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_arm_length <= LW'(11740);
      forearm_length   <= LW'(11901);
      wrist_offset     <= LW'(655);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_UPPER:   upper_arm_length <= cfg_data;
        REG_FOREARM: forearm_length   <= cfg_data;
        REG_WRIST:   wrist_offset     <= cfg_data;
        default: ;
      endcase
    end
  end

  // link geometry in q24: third link drops along z, fifth rises, last reaches out
  always_comb begin
    for (int k = 0; k < NJ; k++) begin
      r_len[k] = '0;
      d_len[k] = '0;
    end
    d_len[2] = -(RW'({upper_arm_length, 8'b0}));
    d_len[4] = RW'({forearm_length, 8'b0});
    r_len[5] = RW'({wrist_offset, 8'b0});
  end

  // valid runs beside the fold register and the cordic stages
  always_ff @(posedge clk) begin
    if (rst) trig_vld <= '0;
    else     trig_vld <= {trig_vld[CORDIC_STEPS-1:0], accept};
  end

  // one cordic lane per joint, all working on the same beat
  for (genvar k = 0; k < NJ; k++) begin : g_lane
    afk_cordic u_cordic (
      .clk   (clk),
      .angle (angle[k]),
      .trig  (lane_t[k])
    );
    // hold each joint's trig until the chain reaches its link
    if (k == 0) begin : g_nodly
      assign lane_d[k] = lane_t[k];
    end else begin : g_dly
      trig_t line [LINK_STAGES*k];
      always_ff @(posedge clk) begin
        line[0] <= lane_t[k];
        for (int j = 1; j < LINK_STAGES * k; j++) line[j] <= line[j-1];
      end
      assign lane_d[k] = line[LINK_STAGES*k-1];
    end
  end

  // chain starts from the identity pose
  always_comb begin
    chain[0].vld = trig_vld[CORDIC_STEPS];
    for (int i = 0; i < 9; i++) chain[0].rot[i] = (i % 4 == 0) ? Q24_ONE : '0;
    for (int i = 0; i < 3; i++) chain[0].pos[i] = '0;
  end

  for (genvar k = 0; k < NJ; k++) begin : g_link
    afk_link u_link (
      .clk      (clk),
      .rst      (rst),
      .off      (LINK_OFF[k]),
      .sf       (LINK_SF[k]),
      .cf       (LINK_CF[k]),
      .trig     (lane_d[k]),
      .r_len    (r_len[k]),
      .d_len    (d_len[k]),
      .pose_in  (chain[k]),
      .pose_out (chain[k+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    col0_x <= sat_out(chain[NJ].rot[0]);
    col0_y <= sat_out(chain[NJ].rot[3]);
    col0_z <= sat_out(chain[NJ].rot[6]);
    col1_x <= sat_out(chain[NJ].rot[1]);
    col1_y <= sat_out(chain[NJ].rot[4]);
    col1_z <= sat_out(chain[NJ].rot[7]);
    col2_x <= sat_out(chain[NJ].rot[2]);
    col2_y <= sat_out(chain[NJ].rot[5]);
    col2_z <= sat_out(chain[NJ].rot[8]);
    pos_x  <= sat_out(chain[NJ].pos[0]);
    pos_y  <= sat_out(chain[NJ].pos[1]);
    pos_z  <= sat_out(chain[NJ].pos[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= chain[NJ].vld;
  end

endmodule
`default_nettype wire

// ----- src/afk_checker.sv -----
// port-level checks for the arm pose block and their binding
`timescale 1ns / 1ps
`default_nettype none
module afk_checker import afk_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input out_t      col0_x,
  input out_t      col2_z
);

  // every result comes from a beat taken a fixed time earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching accepted beat");

  // reset flushes the pipe
  a_flush: assert property (@(posedge clk)
    $fell(rst) |-> !done)
    else $error("result right after reset");

  // rotation entries stay near unit range
  a_rot0: assert property (@(posedge clk) disable iff (rst)
    done |-> (col0_x <= 18'sd66000 && col0_x >= -18'sd66000))
    else $error("rotation entry out of range");

  a_rot8: assert property (@(posedge clk) disable iff (rst)
    done |-> (col2_z <= 18'sd66000 && col2_z >= -18'sd66000))
    else $error("rotation entry out of range");

endmodule

bind arm_forward_kinematics afk_checker u_afk_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .col0_x (col0_x),
  .col2_z (col2_z)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
// self-checking bench for the arm pose block: angle beats in, checked poses out
`timescale 1ns / 1ps
module tb;
  import afk_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [AW-1:0] ang [NJ];
  } joints_t;

  typedef struct {
    out_t f [12];
  } pose_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = REG_UPPER;
  logic [LW-1:0] cfg_data = '0;
  logic signed [AW-1:0] ja [NJ] = '{default: '0};
  out_t col0_x, col0_y, col0_z, col1_x, col1_y, col1_z;
  out_t col2_x, col2_y, col2_z, pos_x, pos_y, pos_z;

  arm_forward_kinematics u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .joint1_angle(ja[0]), .joint2_angle(ja[1]), .joint3_angle(ja[2]),
    .joint4_angle(ja[3]), .joint5_angle(ja[4]), .joint6_angle(ja[5]),
    .col0_x(col0_x), .col0_y(col0_y), .col0_z(col0_z),
    .col1_x(col1_x), .col1_y(col1_y), .col1_z(col1_z),
    .col2_x(col2_x), .col2_y(col2_y), .col2_z(col2_z),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
  );

  // bench copy of the link length registers
  longint unsigned upper_len, fore_len, wrist_len;

  joints_t   angle_queue [$];   // beats waiting to be sent
  pose_out_t pose_queue [$];    // predicted poses in flight
  int idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  string field_name [12] = '{"col0_x", "col0_y", "col0_z", "col1_x", "col1_y", "col1_z",
                             "col2_x", "col2_y", "col2_z", "pos_x", "pos_y", "pos_z"};

  initial forever #1 clk = ~clk;

  // joint sine and cosine: fold into +-pi/2, then 24 cordic rotations
  function automatic void joint_trig(input logic signed [AW-1:0] a,
                                     output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(a) * 2048;
    x = CORDIC_GAIN;
    y = 0;
    flip = 0;
    if (z > HALF_PI_Q) begin
      z -= PI_Q;
      flip = 1;
    end else if (z < -longint'(HALF_PI_Q)) begin
      z += PI_Q;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN[i];
      end else begin
        x += dx; y -= dy; z += ATAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint q24_round(input longint v);
    return (v + (longint'(1) << 23)) >>> 24;
  endfunction

  function automatic out_t q16_sat(input longint v);
    longint r;
    r = (v + 128) >>> 8;
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return out_t'(r);
  endfunction

  // chain the six link transforms from the identity pose
  function automatic pose_out_t arm_pose(input joints_t j);
    longint rot [3][3], nr [3][3], t [3][3];
    longint p [3], np [3], pt [3];
    longint cq, sq, ct, st, sf, cf, r, d, acc;
    pose_out_t o;
    rot = '{'{Q24_ONE, 0, 0}, '{0, Q24_ONE, 0}, '{0, 0, Q24_ONE}};
    p = '{0, 0, 0};
    for (int l = 0; l < NJ; l++) begin
      joint_trig(j.ang[l], cq, sq);
      sf = LINK_SF[l];
      cf = LINK_CF[l];
      case (LINK_OFF[l])
        OFF_POS: begin ct = -sq; st = cq; end
        OFF_NEG: begin ct = sq; st = -cq; end
        default: begin ct = cq; st = sq; end
      endcase
      r = (l == 5) ? longint'(wrist_len) * 256 : 0;
      d = (l == 2) ? -longint'(upper_len) * 256 :
          (l == 4) ? longint'(fore_len) * 256 : 0;
      t = '{'{ct, -st * cf, st * sf}, '{st, ct * cf, -ct * sf},
            '{0, sf * Q24_ONE, cf * Q24_ONE}};
      pt = '{q24_round(r * ct), q24_round(r * st), d};
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += rot[i][k] * t[k][c];
          nr[i][c] = q24_round(acc);
        end
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rot[i][k] * pt[k];
        np[i] = q24_round(acc) + p[i];
      end
      rot = nr;
      p = np;
    end
    for (int c = 0; c < 3; c++)
      for (int i = 0; i < 3; i++) o.f[c * 3 + i] = q16_sat(rot[i][c]);
    for (int i = 0; i < 3; i++) o.f[9 + i] = q16_sat(p[i]);
    return o;
  endfunction

  // driver: predict on every accepted beat, then offer the next one
  always @(posedge clk) begin
    joints_t nx;
    if (!rst) begin
      if (start && !busy) pose_queue.push_back(arm_pose('{ang: ja}));
      if (!start || !busy) begin
        if (angle_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nx = angle_queue.pop_front();
          start <= 1'b1;
          ja <= nx.ang;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: a result lives for one cycle only, so compare on every done
  always @(posedge clk) begin
    pose_out_t want, got;
    bit bad;
    if (!rst && done) begin
      got.f = '{col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
                col2_x, col2_y, col2_z, pos_x, pos_y, pos_z};
      if (pose_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose beat at cycle %0d", cycles);
      end else begin
        want = pose_queue.pop_front();
        bad = 0;
        for (int i = 0; i < 12; i++)
          if (got.f[i] !== want.f[i]) begin
            bad = 1;
            if (mismatches < 10)
              $display("%s: expected %0d, got %0d", field_name[i], want.f[i], got.f[i]);
          end
        if (bad) mismatches++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_angles(input int a1, a2, a3, a4, a5, a6);
    joints_t j;
    j.ang = '{AW'(a1), AW'(a2), AW'(a3), AW'(a4), AW'(a5), AW'(a6)};
    angle_queue.push_back(j);
  endtask

  task automatic push_random(input int n);
    joints_t j;
    for (int k = 0; k < n; k++) begin
      foreach (j.ang[i])
        case ($urandom_range(3))
          0: j.ang[i] = AW'($urandom_range(25736) - 12868);  // within +-pi/2
          1: j.ang[i] = AW'(int'($urandom_range(12869, 12866)) *
                            ($urandom_range(1) ? 1 : -1));
          default: j.ang[i] = AW'($urandom);
        endcase
      angle_queue.push_back(j);
    end
  endtask

  // drain every beat in flight, then let the pipe settle
  task automatic drain();
    while (angle_queue.size() > 0 || start || pose_queue.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_len(input logic [1:0] idx, input logic [LW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    case (idx)
      REG_UPPER:   upper_len = v;
      REG_FOREARM: fore_len = v;
      REG_WRIST:   wrist_len = v;
      default: ;   // index past the register list does nothing
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    upper_len = 11740;
    fore_len = 11901;
    wrist_len = 655;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: zero pose, field extremes, fold boundaries around +-pi/2
    idle_pct = 0;
    push_angles(0, 0, 0, 0, 0, 0);
    push_angles(32767, 32767, 32767, 32767, 32767, 32767);
    push_angles(-32768, -32768, -32768, -32768, -32768, -32768);
    push_angles(12867, 12868, -12867, -12868, 12867, 12868);
    push_angles(-12868, -12867, 12868, 12867, -12868, -12867);
    push_angles(25736, -25736, 0, 12868, -1, 1);
    push_angles(-1, -1, -1, -1, -1, -1);
    push_angles(21845, -21846, 10922, -10923, 32767, -32768);
    drain();

    // long links push the position past the output range
    write_len(REG_UPPER, 16'hffff);
    write_len(REG_FOREARM, 16'hffff);
    write_len(REG_WRIST, 16'hffff);
    write_len(2'd3, 16'h1234);
    push_angles(0, 0, 0, 0, 0, 0);
    push_angles(0, 12868, 0, 0, 0, 0);
    push_angles(0, -12868, 0, 0, 0, 0);
    push_angles(12868, 0, 12868, 0, 12868, 0);
    push_angles(-32768, 32767, -32768, 32767, -32768, 32767);
    push_random(60);
    drain();

    // all lengths zero, sender mostly idle
    write_len(REG_UPPER, 16'h0000);
    write_len(REG_FOREARM, 16'h0000);
    write_len(REG_WRIST, 16'h0000);
    idle_pct = 80;
    push_random(150);
    drain();

    // back to the nominal arm, back-to-back beats
    write_len(REG_UPPER, 16'd11740);
    write_len(REG_FOREARM, 16'd11901);
    write_len(REG_WRIST, 16'd655);
    idle_pct = 0;
    push_random(250);
    drain();

    // random lengths, light idling
    write_len(REG_UPPER, LW'($urandom));
    write_len(REG_FOREARM, LW'($urandom));
    write_len(REG_WRIST, LW'($urandom));
    idle_pct = 27;
    push_random(220);
    drain();

    write_len(REG_UPPER, LW'($urandom));
    write_len(REG_FOREARM, LW'($urandom));
    write_len(REG_WRIST, LW'($urandom));
    idle_pct = 80;
    push_random(200);
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
